// File: rtl/cjk_line_splitter_normalizer_top_macros.svh
// Assertion macros shared by the line splitter and normaliser RTL.
`ifndef CJK_LINE_SPLITTER_NORMALIZER_TOP_MACROS_SVH
`define CJK_LINE_SPLITTER_NORMALIZER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CJKLSN_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cjklsn assertion failed");

// Next-cycle implication, checked outside reset.
`define CJKLSN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cjklsn assertion failed");

`endif

// File: rtl/cjklsn_pkg.sv
// Package with the types, constants and character tables of the line splitter.
package cjklsn_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int MIN_W      = 7;
    localparam logic REG_MIN_LINE_CHARS = 1'b0;
    localparam logic [MIN_W-1:0] MIN_LINE_CHARS_RESET = 7'd2;

    localparam int CP_W   = 21;
    localparam int CHAR_W = 18;

    localparam int TABLE_SIZE  = 60;
    localparam int DELIM_COUNT = 39;

    localparam logic [15:0] TRAD_FROM [TABLE_SIZE] = '{
        16'h570B, 16'h98A8, 16'h8A69, 16'h8A5E, 16'h842C, 16'h8207, 16'h70BA, 16'h5F8C,
        16'h7121, 16'h9577, 16'h6A02, 16'h9580, 16'h6642, 16'h6771, 16'h897F, 16'h96F2,
        16'h9F8D, 16'h4F86, 16'h6B78, 16'h958B, 16'h898B, 16'h805E, 16'h9670, 16'h967D,
        16'h5C0D, 16'h8208, 16'h81FA, 16'h6A13, 16'h756B, 16'h99AC, 16'h9CE5, 16'h9B5A,
        16'h66F8, 16'h8ECA, 16'h7D05, 16'h7DA0, 16'h9EC3, 16'h611B, 16'h528D, 16'h908A,
        16'h6DDA, 16'h6FE4, 16'h95DC, 16'h8072, 16'h8655, 16'h8449, 16'h98DB, 16'h904E,
        16'h9084, 16'h9109, 16'h5BE6, 16'h865B, 16'h6C23, 16'h5BF6, 16'h5289, 16'h9673,
        16'h5F35, 16'h7C21, 16'h9AD4, 16'h9418
    };

    localparam logic [15:0] SIMP_TO [TABLE_SIZE] = '{
        16'h56FD, 16'h98CE, 16'h8BD7, 16'h8BCD, 16'h4E07, 16'h4E0E, 16'h4E3A, 16'h540E,
        16'h65E0, 16'h957F, 16'h4E50, 16'h95E8, 16'h65F6, 16'h4E1C, 16'h897F, 16'h4E91,
        16'h9F99, 16'h6765, 16'h5F52, 16'h5F00, 16'h89C1, 16'h95FB, 16'h9634, 16'h9633,
        16'h5BF9, 16'h5174, 16'h53F0, 16'h697C, 16'h753B, 16'h9A6C, 16'h9E1F, 16'h9C7C,
        16'h4E66, 16'h8F66, 16'h7EA2, 16'h7EFF, 16'h9EC4, 16'h7231, 16'h5251, 16'h8FB9,
        16'h6CEA, 16'h6D9B, 16'h5173, 16'h58F0, 16'h5904, 16'h53F6, 16'h98DE, 16'h8FC7,
        16'h8FD8, 16'h4E61, 16'h5B9E, 16'h865A, 16'h6C14, 16'h5B9D, 16'h5218, 16'h9648,
        16'h5F20, 16'h7B80, 16'h4F53, 16'h949F
    };

    localparam logic [15:0] DELIMS [DELIM_COUNT] = '{
        16'hFF0C, 16'h3002, 16'hFF01, 16'hFF1F, 16'hFF1B, 16'hFF1A, 16'h3001, 16'h002C,
        16'h002E, 16'h0021, 16'h003F, 16'h003B, 16'h003A, 16'hFF08, 16'hFF09, 16'h0028,
        16'h0029, 16'h005B, 16'h005D, 16'h3010, 16'h3011, 16'h300A, 16'h300B, 16'h3008,
        16'h3009, 16'h300C, 16'h300D, 16'h300E, 16'h300F, 16'h0022, 16'h201C, 16'h201D,
        16'h2018, 16'h2019, 16'h2014, 16'h002D, 16'h005F, 16'h00B7, 16'h2026
    };

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            paragraph_end;
    } in_beat_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              line_last;
        logic              line_truncated;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic rd_first;
        logic drain_load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic flush_req;
        logic emit_ok;
        logic out_free;
        logic last;
    } sts_t;

    function automatic logic [CP_W-1:0] normalize_cp(input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] v;
        logic [CP_W-1:0] r;
        v = cp;
        if (cp >= 21'h0FF01 && cp <= 21'h0FF5E) begin
            v = cp - 21'h0FEE0;
        end
        r = v;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (v == {5'd0, TRAD_FROM[i]}) begin
                r = {5'd0, SIMP_TO[i]};
            end
        end
        if (cp == 21'h03000) begin
            r = 21'h00020;
        end
        return r;
    endfunction

    function automatic logic is_break(input logic [CP_W-1:0] cp);
        logic hit;
        hit = (cp == 21'h0000A) || (cp == 21'h0000D);
        for (int i = 0; i < DELIM_COUNT; i++) begin
            if (cp == {5'd0, DELIMS[i]}) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic is_ideograph(input logic [CP_W-1:0] cp);
        return (cp >= 21'h04E00 && cp <= 21'h09FFF)
            || (cp >= 21'h03400 && cp <= 21'h04DBF)
            || (cp >= 21'h20000 && cp <= 21'h2A6DF)
            || (cp >= 21'h2A700 && cp <= 21'h2CEAF)
            || (cp >= 21'h0F900 && cp <= 21'h0FAFF);
    endfunction

endpackage

// File: rtl/cjk_line_splitter_normalizer_top.sv
// Top level of the line splitter and normaliser: channels, APB register and the two halves.
//
// The s_ channel carries one code point per beat with a paragraph-end flag; the m_ channel
// returns the normalised ideographs of each kept line, one per beat, the final one marked
// with line_last and every beat of an overflowed line marked with line_truncated.
// Each input beat is registered in the idle state, then normalised, classified and
// appended to the line store in the exec state. A beat that ends a line adds a
// threshold check; a kept line then drains from the line store RAM at one beat per cycle
// while the receiver accepts, and the input is held until the drain ends. The registered
// read port of the line store is first read in the check state, before the first result.
// While the receiver stalls, the drain holds its place and s_ready stays low; once the
// last beat sits in the output register, new input is taken again.
// Reset empties the line, clears the overflow flag and sets min_line_chars to two; the
// store contents need no clearing. min_line_chars lives at byte address 0; the user must
// write it only while the block is idle, and the block itself does not enforce this.
module cjk_line_splitter_normalizer_top
    import cjklsn_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [MIN_W-1:0] min_reg;
    logic             reg_sel;
    cmd_t             cmd;
    sts_t             sts;

    assign reg_sel = paddr[APB_ADDR_W-1:2] == REG_MIN_LINE_CHARS;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(APB_DATA_W - MIN_W){1'b0}}, min_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= MIN_LINE_CHARS_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            min_reg <= pwdata[MIN_W-1:0];
        end
    end

    cjklsn_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    cjklsn_dp #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data        (s_data),
        .m_data        (m_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .min_line_chars(min_reg),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// File: rtl/cjklsn_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module cjklsn_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/cjklsn_ctrl.sv
// Controller state machine that sequences input, append, flush check and drain.
module cjklsn_ctrl
    import cjklsn_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.flush_req ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK: begin
                if (sts.emit_ok) begin
                    cmd.rd_first = 1'b1;
                    state_next   = ST_DRAIN;
                end else begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (sts.out_free) begin
                    cmd.drain_load = 1'b1;
                    if (sts.last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/cjklsn_dp.sv
// Datapath: input register, normaliser, line store, counters and output register.
`include "cjk_line_splitter_normalizer_top_macros.svh"

module cjklsn_dp
    import cjklsn_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  in_beat_t         s_data,
    output out_beat_t        m_data,
    output logic             m_valid,
    input  logic             m_ready,
    input  logic [MIN_W-1:0] min_line_chars,
    input  cmd_t             cmd,
    output sts_t             sts
);

    localparam int AW = $clog2(LINE_CAPACITY);
    localparam int CW = $clog2(LINE_CAPACITY + 1);

    in_beat_t        in_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            ovf_reg;
    logic            ovf_next;
    logic [AW-1:0]   idx_reg;
    logic [AW-1:0]   idx_next;
    logic            m_valid_reg;
    out_beat_t       m_data_reg;

    logic [CP_W-1:0] norm_cp;
    logic            ideo;
    logic            room;
    logic            ram_we;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    assign norm_cp = normalize_cp(in_reg.code_point);
    assign ideo    = is_ideograph(norm_cp);
    assign room    = count_reg < CW'(LINE_CAPACITY);

    assign sts.flush_req = is_break(norm_cp) || in_reg.paragraph_end;
    assign sts.emit_ok   = (count_reg != '0) && (MIN_W'(count_reg) >= min_line_chars);
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.last      = (CW'(idx_reg) + CW'(1)) == count_reg;

    assign ram_we    = cmd.exec && ideo && room;
    assign ram_re    = cmd.rd_first || (cmd.drain_load && !sts.last);
    assign ram_raddr = cmd.rd_first ? '0 : AW'(idx_reg + AW'(1));

    cjklsn_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(LINE_CAPACITY)
    ) u_line_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(norm_cp[CHAR_W-1:0]),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        if (cmd.exec && ideo) begin
            if (room) begin
                count_next = count_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.rd_first) begin
            idx_next = '0;
        end else if (cmd.drain_load && !sts.last) begin
            idx_next = ram_raddr;
        end
        if (cmd.clear) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            if (cmd.drain_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.drain_load) begin
            m_data_reg.char_out       <= ram_rdata;
            m_data_reg.line_last      <= sts.last;
            m_data_reg.line_truncated <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `CJKLSN_ASSERT_NEXT(a_clear_empties, aclk, aresetn, cmd.clear, count_reg == '0 && !ovf_reg)
    `CJKLSN_ASSERT_NEXT(a_last_beat, aclk, aresetn, cmd.drain_load && sts.last, m_valid && m_data.line_last)
    `CJKLSN_ASSERT_NOW(a_ovf_at_full, aclk, aresetn, $rose(ovf_reg), count_reg == CW'(LINE_CAPACITY))

endmodule
